// ===== design/ps2_mouse_packet_cursor_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// Checked only while the block is out of reset.
`define PS2MCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PS2MCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/ps2mct_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Widths, reset values, status byte layout and register map.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ByteW  = 8;
  // Sum of a 12-bit coordinate and a 9-bit signed delta, with sign.
  localparam int unsigned SumW   = CoordW + 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned OutW   = 32;
  localparam int unsigned AddrW  = 3;

  localparam logic [CoordW-1:0] CursorReset = CoordW'(100);
  localparam logic [CoordW-1:0] MaxXReset   = CoordW'(1023);
  localparam logic [CoordW-1:0] MaxYReset   = CoordW'(767);

  // Status byte bit positions.
  localparam int unsigned BitLeft  = 0;
  localparam int unsigned BitRight = 1;
  localparam int unsigned BitSync  = 3;
  localparam int unsigned BitXSign = 4;
  localparam int unsigned BitYSign = 5;
  localparam int unsigned BitXOvf  = 6;
  localparam int unsigned BitYOvf  = 7;

  // Register index, taken from paddr[2].
  localparam logic RegMaxX = 1'b0;
  localparam logic RegMaxY = 1'b1;

  typedef enum logic [1:0] {
    SLOT_STATUS = 2'd0,
    SLOT_DX     = 2'd1,
    SLOT_DY     = 2'd2
  } slot_e;

  typedef struct packed {
    logic              moved;
    logic              right_button;
    logic              left_button;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_x;
  } result_t;

endpackage

// ===== design/ps2_mouse_packet_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Gathers three-byte mouse packets and keeps a bounded cursor position.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         rx_byte, one transaction per received mouse byte
//  m_axis    out        pos_x, pos_y, buttons, moved; one per complete packet
//  apb       in/out     max_x at 0x0, max_y at 0x4
//
// One byte is taken per cycle unless a third byte waits on a stalled result;
// the add and bound compare run between the input and result registers.
// Reset clears the byte slot and puts the cursor at (100, 100).
// A stalled result holds back only a third packet byte; others still pass.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker
  import ps2mct_pkg::*;
#(
  parameter logic [CoordW-1:0] MAX_X_RESET = MaxXReset,
  parameter logic [CoordW-1:0] MAX_Y_RESET = MaxYReset
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [11:0] pos_x, [23:12] pos_y, [24] left_button, [25] right_button,
  // [26] moved, [31:27] zero
  output logic [OutW-1:0]  m_axis_tdata_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic              in_valid_q, in_valid_d;
  logic [ByteW-1:0]  in_byte_q;
  slot_e             slot_q, slot_d;
  logic [ByteW-1:0]  status_q, dx_q;
  logic [CoordW-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [CoordW-1:0] max_x_q, max_y_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              out_free, fire, out_load, cfg_wr;
  logic              overflow, in_x, in_y, take;
  logic [SumW-1:0]   dx_ext, dy_ext, nx, ny;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      RegMaxX: prdata = DataW'(max_x_q);
      RegMaxY: prdata = DataW'(max_y_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= MAX_X_RESET;
      max_y_q <= MAX_Y_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegMaxX: max_x_q <= pwdata[CoordW-1:0];
        RegMaxY: max_y_q <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. Only a third packet byte needs room in the result register.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && ((slot_q != SLOT_DY) || out_free);
  assign out_load        = fire && (slot_q == SLOT_DY);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !fire);
  assign out_valid_d     = out_load || (out_valid_q && !m_axis_tready_i);

  // Movement arithmetic: each delta is a sign bit from the status byte on
  // top of its data byte, widened so that sums and bound checks are signed.
  assign overflow = status_q[BitXOvf] || status_q[BitYOvf];
  assign dx_ext   = {{(SumW-ByteW){status_q[BitXSign]}}, dx_q};
  assign dy_ext   = {{(SumW-ByteW){status_q[BitYSign]}}, in_byte_q};
  assign nx       = {2'b00, cursor_x_q} + dx_ext;
  assign ny       = {2'b00, cursor_y_q} - dy_ext;
  assign in_x     = !nx[SumW-1] && (nx[SumW-2:0] <= {1'b0, max_x_q});
  assign in_y     = !ny[SumW-1] && (ny[SumW-2:0] <= {1'b0, max_y_q});
  assign take     = !overflow && in_x && in_y;

  // Next slot
  always_comb begin
    slot_d = slot_q;
    if (fire) begin
      unique case (slot_q)
        SLOT_DX: slot_d = SLOT_DY;
        SLOT_DY: slot_d = SLOT_STATUS;
        default: slot_d = in_byte_q[BitSync] ? SLOT_DX : SLOT_STATUS;
      endcase
    end
  end

  // Cursor and result
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (out_load && take) begin
      cursor_x_d = nx[CoordW-1:0];
      cursor_y_d = ny[CoordW-1:0];
    end
    out_d.pos_x        = cursor_x_d;
    out_d.pos_y        = cursor_y_d;
    out_d.left_button  = status_q[BitLeft];
    out_d.right_button = status_q[BitRight];
    out_d.moved        = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slot_q      <= SLOT_STATUS;
      cursor_x_q  <= CursorReset;
      cursor_y_q  <= CursorReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (fire && (slot_q == SLOT_DX)) begin
      dx_q <= in_byte_q;
    end
    if (fire && (slot_q != SLOT_DX) && (slot_q != SLOT_DY) && in_byte_q[BitSync]) begin
      status_q <= in_byte_q;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'(out_q);

  // Assertions
  `include "ps2_mouse_packet_cursor_tracker_macros.svh"

  // The slot may still be unknown at the first edge if reset was already low at start-up.
  `PS2MCT_ASSERT_ALWAYS(a_slot_legal,
                        !rst_ni || (slot_q == SLOT_STATUS) || (slot_q == SLOT_DX) ||
                        (slot_q == SLOT_DY),
                        "byte slot reached an unused code")
  `PS2MCT_ASSERT(a_load_on_dy, out_load |-> (slot_q == SLOT_DY) && out_free,
                 "result loaded outside the third packet byte or while the output is full")
  `PS2MCT_ASSERT(a_out_tracks_cursor,
                 out_valid_q |-> (out_q.pos_x == cursor_x_q) && (out_q.pos_y == cursor_y_q),
                 "pending result does not match the held cursor")
  `PS2MCT_ASSERT(a_cursor_moves_only_when_moved,
                 (!$stable(cursor_x_q) || !$stable(cursor_y_q)) |-> out_valid_q && out_q.moved,
                 "cursor changed without a moved result")

endmodule

// ===== verif/ps2_mouse_packet_cursor_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker testbench
// Streams mouse bytes into the tracker through a short directed table and
// then random packets with noise, under several max_x / max_y settings. A
// cursor tracker kept alongside the block predicts each report the table
// does not give, and the reports coming out are compared in order.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_tb;
  import ps2mct_pkg::*;

  localparam int unsigned ResW      = $bits(result_t);
  localparam int unsigned TimeoutNs = 2_000_000;

  typedef struct packed {
    logic [ByteW-1:0]  rx;
    logic              typed;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              lb;
    logic              rb;
    logic              mv;
  } dir_row_t;

  // Rows with typed set carry a report that is plain from the packet.
  localparam dir_row_t DirTab [23] = '{
    '{8'h00, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},  // unsynchronised, dropped
    '{8'hF7, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},  // all bits but sync, dropped
    '{8'h08, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 12'd100, 12'd100, 1'b0, 1'b0, 1'b1},  // zero movement is accepted
    '{8'h0B, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 12'd100, 12'd100, 1'b1, 1'b1, 1'b0},  // y goes below zero
    '{8'h38, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 12'd100, 12'd100, 1'b0, 1'b0, 1'b0},  // x goes below zero
    '{8'h49, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 12'd100, 12'd100, 1'b1, 1'b0, 1'b0},  // x overflow
    '{8'h8A, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h7F, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, 12'd100, 12'd100, 1'b0, 1'b1, 1'b0},  // y overflow
    '{8'h28, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h9C, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h9C, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h18, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0},
    '{8'h7F, 1'b0, 12'd0,   12'd0,   1'b0, 1'b0, 1'b0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [ByteW-1:0]  s_axis_tdata_i;   // [7:0] rx_byte
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  // [11:0] pos_x, [23:12] pos_y, [24] left_button, [25] right_button,
  // [26] moved, [31:27] zero
  logic [OutW-1:0]   m_axis_tdata_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // Tracker state kept by the testbench.
  slot_e             slot;
  logic [ByteW-1:0]  status_hold;
  logic [ByteW-1:0]  dx_hold;
  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;
  logic [CoordW-1:0] lim_x;
  logic [CoordW-1:0] lim_y;

  result_t           pending_reports [$];
  int unsigned       bytes_taken;
  int unsigned       mismatches;
  bit                calm;
  bit                drv_typed;
  result_t           drv_report;
  int unsigned       stall_left;

  ps2_mouse_packet_cursor_tracker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advances the tracker by one byte; returns 1 when the byte completes a packet.
  function automatic bit track_byte(input logic [ByteW-1:0] b, output result_t rep);
    int ddx, ddy, nx, ny;
    rep = '0;
    if (slot == SLOT_DX) begin
      dx_hold = b;
      slot = SLOT_DY;
      return 1'b0;
    end
    if (slot != SLOT_DY) begin
      if (b[BitSync]) begin
        status_hold = b;
        slot = SLOT_DX;
      end else begin
        slot = SLOT_STATUS;
      end
      return 1'b0;
    end
    slot = SLOT_STATUS;
    if (!status_hold[BitXOvf] && !status_hold[BitYOvf]) begin
      ddx = status_hold[BitXSign] ? int'(dx_hold) - 256 : int'(dx_hold);
      ddy = status_hold[BitYSign] ? int'(b) - 256 : int'(b);
      nx = int'(cur_x) + ddx;
      ny = int'(cur_y) - ddy;
      if (nx >= 0 && nx <= int'(lim_x) && ny >= 0 && ny <= int'(lim_y)) begin
        cur_x = CoordW'(nx);
        cur_y = CoordW'(ny);
        rep.moved = 1'b1;
      end
    end
    rep.pos_x        = cur_x;
    rep.pos_y        = cur_y;
    rep.left_button  = status_hold[BitLeft];
    rep.right_button = status_hold[BitRight];
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // Outputs are sampled here, inputs change on the falling edge.
  always @(posedge clk_i) begin : monitor
    result_t got, want, pred;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[ResW-1:0];
        if (pending_reports.size() == 0) begin
          note_mismatch($sformatf("unexpected report x=%0d y=%0d", got.pos_x, got.pos_y));
        end else begin
          want = pending_reports.pop_front();
          if (got !== want || m_axis_tdata_o[OutW-1:ResW] !== '0) begin
            note_mismatch($sformatf(
              "report: expected x=%0d y=%0d l=%0b r=%0b mv=%0b, got x=%0d y=%0d l=%0b r=%0b mv=%0b pad=%0h",
              want.pos_x, want.pos_y, want.left_button, want.right_button, want.moved,
              got.pos_x, got.pos_y, got.left_button, got.right_button, got.moved,
              m_axis_tdata_o[OutW-1:ResW]));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        bytes_taken++;
        if (track_byte(s_axis_tdata_i, pred)) begin
          pending_reports.push_back(drv_typed ? drv_report : pred);
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready_i = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance and any random pause.
  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input result_t rep);
    int unsigned seen;
    drv_typed = typed;
    drv_report = rep;
    s_axis_tdata_i = b;
    s_axis_tvalid_i = 1'b1;
    seen = bytes_taken;
    do @(negedge clk_i); while (bytes_taken == seen);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  task automatic drain;
    s_axis_tvalid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    // A byte without a report may still sit in the input register.
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [CoordW-1:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrW'({idx, 2'b00});
    pwdata = DataW'(v);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == RegMaxX) lim_x = v;
    else lim_y = v;
  endtask

  // Mostly whole packets with random or small deltas, with stray bytes between.
  task automatic random_bytes(input int unsigned count, input bit mid_pause);
    int unsigned sent;
    int d;
    logic [ByteW-1:0] st, dxb, dyb;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      if (mid_pause && !paused && sent >= count / 2) begin
        paused = 1'b1;
        s_axis_tvalid_i = 1'b0;
        while (pending_reports.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(ByteW'($urandom), 1'b0, '0);
        sent++;
      end else begin
        st = ByteW'($urandom);
        st[BitSync] = 1'b1;
        if ($urandom_range(0, 7) != 0) begin
          st[BitXOvf] = 1'b0;
          st[BitYOvf] = 1'b0;
        end
        dxb = ByteW'($urandom);
        dyb = ByteW'($urandom);
        if ($urandom_range(0, 2) != 0) begin
          d = int'($urandom_range(0, 40)) - 20;
          st[BitXSign] = (d < 0);
          dxb = ByteW'(d);
          d = int'($urandom_range(0, 40)) - 20;
          st[BitYSign] = (d < 0);
          dyb = ByteW'(d);
        end
        send_byte(st, 1'b0, '0);
        send_byte(dxb, 1'b0, '0);
        send_byte(dyb, 1'b0, '0);
        sent += 3;
      end
    end
  endtask

  initial begin : stimulus
    result_t rep;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    drv_typed = 1'b0;
    drv_report = '0;
    stall_left = 0;
    bytes_taken = 0;
    mismatches = 0;
    slot = SLOT_STATUS;
    status_hold = '0;
    dx_hold = '0;
    cur_x = CursorReset;
    cur_y = CursorReset;
    lim_x = MaxXReset;
    lim_y = MaxYReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirTab[i]) begin
      rep = '0;
      rep.pos_x = DirTab[i].x;
      rep.pos_y = DirTab[i].y;
      rep.left_button = DirTab[i].lb;
      rep.right_button = DirTab[i].rb;
      rep.moved = DirTab[i].mv;
      send_byte(DirTab[i].rx, DirTab[i].typed, rep);
    end

    random_bytes(90, 1'b1);
    drain();
    reg_write(RegMaxX, 12'd4095);
    reg_write(RegMaxY, 12'd4095);
    random_bytes(90, 1'b0);
    drain();
    reg_write(RegMaxX, 12'd0);
    reg_write(RegMaxY, 12'd0);
    random_bytes(60, 1'b0);
    drain();
    // Held cursor may now lie beyond the lowered bounds.
    reg_write(RegMaxX, 12'd150);
    reg_write(RegMaxY, 12'd90);
    random_bytes(90, 1'b0);
    drain();
    reg_write(RegMaxX, CoordW'($urandom));
    reg_write(RegMaxY, CoordW'($urandom));
    random_bytes(90, 1'b0);
    drain();
    reg_write(RegMaxX, MaxXReset);
    reg_write(RegMaxY, MaxYReset);
    calm = 1'b1;
    random_bytes(120, 1'b0);

    s_axis_tvalid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

endmodule
